@@ rtl/gsp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsp_pkg - shared types and constants for the generational slot pool
// Pool geometry, command and status codes, sequencer states and the
// coordinate conversion helpers.
// ----------------------------------------------------------------------------
package gsp_pkg;

  // Pool geometry
  localparam int SLOT_COUNT = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int SCAN_W     = IDX_W + 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W      = 8;
  localparam int THR_W      = 9;
  localparam int DIST_W     = 2 * COORD_BITS + 2;
  localparam int POS_W      = 3 * COORD_BITS;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

  // Command codes
  localparam logic [2:0] CMD_SPAWN   = 3'd0;
  localparam logic [2:0] CMD_RESOLVE = 3'd1;
  localparam logic [2:0] CMD_SETPOS  = 3'd2;
  localparam logic [2:0] CMD_EVICT   = 3'd3;
  localparam logic [2:0] CMD_COUNT   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAWN_SCAN,
    S_SPAWN_RD,
    S_SPAWN_WR,
    S_RES_RD,
    S_RES_CHK,
    S_SETPOS,
    S_EV_NEXT,
    S_EV_RD,
    S_EV_AX,
    S_EV_CMP,
    S_EV_FREE,
    S_OUT
  } gsp_state_t;

  // Control of the shared distance unit
  typedef struct packed {
    logic en;     // take one axis this cycle
    logic first;  // first axis of a slot: restart the sum
  } gsp_dist_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] handle;
    logic        found;
    logic [15:0] model;
    logic        deletable;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
  } gsp_result_t;

  // 16-bit port coordinate into the internal coordinate width
  function automatic coord_t coord_in(input logic [15:0] raw);
    logic signed [31:0] ext;
    ext = 32'(signed'(raw));
    return ext[COORD_BITS-1:0];
  endfunction

  // Internal coordinate back to the 16-bit port field
  function automatic logic [15:0] coord_out(input coord_t c);
    logic signed [31:0] ext;
    ext = 32'(c);
    return ext[15:0];
  endfunction

endpackage

@@ rtl/generational_slot_pool_top.sv @@
// ----------------------------------------------------------------------------
// generational_slot_pool_top - generational handle slot pool
// Fixed pool of slots with generation-checked handles, a closest-slot
// eviction and a small sequencer around one shared distance unit.
// ----------------------------------------------------------------------------
// One command is in work at a time; in_ready is high only while the
// sequencer is idle, and a finished result may still sit in the output
// register while the next command is taken. Count, rejected commands and
// a resolve of a zero handle go straight to the output state.
// Spawn walks the live bits one slot a cycle from slot 0 up to the first
// free slot, then reads and writes that slot. Evict refused by the
// threshold goes straight to the output state. Otherwise it walks every
// slot once, one slot a cycle between measurements, and measures each live
// deletable slot: a position memory read, three axes through the shared
// square-and-add unit, then a compare against the best so far. A result
// waits while the output register is full. Generation, model and position
// live in single-port memories with registered reads; generations carry a
// written bit per slot so they read as zero after reset.
// The threshold register may be written at any time the pool is idle.
// ----------------------------------------------------------------------------
module generational_slot_pool_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [13:0] in_handle_in,
  input  logic [15:0] in_model_number,
  input  logic        in_deletable_in,
  input  logic [5:0]  in_slot_index,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [15:0] in_coord_z,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [13:0] out_handle_out,
  output logic        out_found,
  output logic [15:0] out_model_out,
  output logic        out_deletable_out,
  output logic [15:0] out_pos_x_out,
  output logic [15:0] out_pos_y_out,
  output logic [15:0] out_pos_z_out,
  output logic [6:0]  out_live_count
);
  import gsp_pkg::*;

  // Sequencer and per-command registers
  gsp_state_t         state_r, state_nxt;
  logic [SCAN_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic               have_r, have_nxt;
  logic [DIST_W-1:0]  best_r, best_nxt;
  logic [IDX_W-1:0]   sel_r, sel_nxt;
  gsp_result_t        res_r, res_nxt;

  // Command operands captured at the input transfer
  logic [7:0]         gen_in_r, gen_in_nxt;
  logic [15:0]        model_in_r, model_in_nxt;
  logic               del_in_r, del_in_nxt;
  coord_t             cam_x_r, cam_x_nxt;
  coord_t             cam_y_r, cam_y_nxt;
  coord_t             cam_z_r, cam_z_nxt;

  // Pool state in flops
  logic [SLOT_COUNT-1:0] live_r, live_nxt;
  logic [SLOT_COUNT-1:0] del_r, del_nxt;
  logic [SLOT_COUNT-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0]      live_total_r, live_total_nxt;
  logic [THR_W-1:0]      thr_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  gsp_result_t        out_r, out_nxt;
  logic [6:0]         out_cnt_r, out_cnt_nxt;

  // Memories, single address per cycle, registered read
  logic [GEN_W-1:0]   gen_mem   [SLOT_COUNT];
  logic [15:0]        model_mem [SLOT_COUNT];
  logic [POS_W-1:0]   pos_mem   [SLOT_COUNT];
  logic [GEN_W-1:0]   gen_rd_r;
  logic [15:0]        model_rd_r;
  logic [POS_W-1:0]   pos_rd_r;
  logic               seen_rd_r;

  logic               gen_we, model_we, pos_we;
  logic [GEN_W-1:0]   gen_wdata;
  logic [POS_W-1:0]   pos_wdata;

  // Distance unit hookup
  gsp_dist_ctl_t      dctl;
  coord_t             dist_a, dist_b;
  logic [DIST_W-1:0]  dist_sum;

  // Helpers
  logic               in_xfer;
  logic               out_free;
  logic [8:0]         hidx9, sidx9;
  logic [THR_W-1:0]   free_slots;
  logic [GEN_W-1:0]   gen_cur, gen_bump;
  logic [15:0]        hwide;
  coord_t             rd_x, rd_y, rd_z;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign hidx9      = 9'(in_handle_in[13:8]);
  assign sidx9      = 9'(in_slot_index);
  assign free_slots = THR_W'(SLOT_COUNT) - THR_W'(live_total_r);

  assign gen_cur  = seen_rd_r ? gen_rd_r : '0;
  assign gen_bump = (gen_cur == 8'hFF) ? GEN_W'(1) : gen_cur + GEN_W'(1);
  assign hwide    = {8'(addr_r), gen_bump};

  assign rd_x = pos_rd_r[COORD_BITS-1:0];
  assign rd_y = pos_rd_r[2*COORD_BITS-1:COORD_BITS];
  assign rd_z = pos_rd_r[3*COORD_BITS-1:2*COORD_BITS];

  // axis select for the shared unit
  always_comb begin
    case (ax_r)
      2'd0:    begin dist_a = rd_x; dist_b = cam_x_r; end
      2'd1:    begin dist_a = rd_y; dist_b = cam_y_r; end
      default: begin dist_a = rd_z; dist_b = cam_z_r; end
    endcase
  end

  gsp_dist u_dist (
    .clk      (clk),
    .ctl      (dctl),
    .a        (dist_a),
    .b        (dist_b),
    .dist_sum (dist_sum)
  );

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    ax_nxt         = ax_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    sel_nxt        = sel_r;
    res_nxt        = res_r;
    gen_in_nxt     = gen_in_r;
    model_in_nxt   = model_in_r;
    del_in_nxt     = del_in_r;
    cam_x_nxt      = cam_x_r;
    cam_y_nxt      = cam_y_r;
    cam_z_nxt      = cam_z_r;
    live_nxt       = live_r;
    del_nxt        = del_r;
    seen_nxt       = seen_r;
    live_total_nxt = live_total_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_cnt_nxt    = out_cnt_r;
    gen_we         = 1'b0;
    model_we       = 1'b0;
    pos_we         = 1'b0;
    gen_wdata      = gen_bump;
    pos_wdata      = {cam_z_r, cam_y_r, cam_x_r};
    dctl           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt        = '0;
          res_nxt.status = ST_NONE;
          gen_in_nxt     = in_handle_in[7:0];
          model_in_nxt   = in_model_number;
          del_in_nxt     = in_deletable_in;
          cam_x_nxt      = coord_in(in_coord_x);
          cam_y_nxt      = coord_in(in_coord_y);
          cam_z_nxt      = coord_in(in_coord_z);
          cnt_nxt        = '0;
          have_nxt       = 1'b0;
          case (in_command)
            CMD_SPAWN: begin
              state_nxt = S_SPAWN_SCAN;
            end
            CMD_RESOLVE: begin
              addr_nxt = hidx9[IDX_W-1:0];
              if (in_handle_in != '0 && hidx9 < 9'(SLOT_COUNT)) begin
                state_nxt = S_RES_RD;
              end else begin
                state_nxt = S_OUT;
              end
            end
            CMD_SETPOS: begin
              addr_nxt = sidx9[IDX_W-1:0];
              if (sidx9 < 9'(SLOT_COUNT)) begin
                state_nxt = S_SETPOS;
              end else begin
                state_nxt = S_OUT;
              end
            end
            CMD_EVICT: begin
              if (free_slots < thr_r) begin
                state_nxt = S_EV_NEXT;
              end else begin
                state_nxt = S_OUT;
              end
            end
            CMD_COUNT: begin
              res_nxt.status = ST_OK;
              state_nxt      = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // lowest free slot, one slot a cycle
      S_SPAWN_SCAN: begin
        if (!live_r[cnt_r[IDX_W-1:0]]) begin
          addr_nxt  = cnt_r[IDX_W-1:0];
          state_nxt = S_SPAWN_RD;
        end else if (cnt_r[IDX_W-1:0] == IDX_W'(SLOT_COUNT - 1)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_OUT;
        end
        cnt_nxt = cnt_r + SCAN_W'(1);
      end

      S_SPAWN_RD: begin
        state_nxt = S_SPAWN_WR;
      end

      S_SPAWN_WR: begin
        gen_we                 = 1'b1;
        model_we               = 1'b1;
        pos_we                 = 1'b1;
        pos_wdata              = '0;
        seen_nxt[addr_r]       = 1'b1;
        live_nxt[addr_r]       = 1'b1;
        del_nxt[addr_r]        = del_in_r;
        live_total_nxt         = live_total_r + CNT_W'(1);
        res_nxt.status         = ST_OK;
        res_nxt.handle         = hwide[13:0];
        state_nxt              = S_OUT;
      end

      S_RES_RD: begin
        state_nxt = S_RES_CHK;
      end

      S_RES_CHK: begin
        if (live_r[addr_r] && gen_cur == gen_in_r) begin
          res_nxt.status    = ST_OK;
          res_nxt.found     = 1'b1;
          res_nxt.model     = model_rd_r;
          res_nxt.deletable = del_r[addr_r];
          res_nxt.pos_x     = coord_out(rd_x);
          res_nxt.pos_y     = coord_out(rd_y);
          res_nxt.pos_z     = coord_out(rd_z);
        end
        state_nxt = S_OUT;
      end

      S_SETPOS: begin
        if (live_r[addr_r]) begin
          pos_we         = 1'b1;
          res_nxt.status = ST_OK;
          res_nxt.found  = 1'b1;
        end
        state_nxt = S_OUT;
      end

      // walk all slots, measure only live deletable ones
      S_EV_NEXT: begin
        if (cnt_r == SCAN_W'(SLOT_COUNT)) begin
          state_nxt = have_r ? S_EV_FREE : S_OUT;
        end else begin
          if (live_r[cnt_r[IDX_W-1:0]] && del_r[cnt_r[IDX_W-1:0]]) begin
            addr_nxt  = cnt_r[IDX_W-1:0];
            state_nxt = S_EV_RD;
          end
          cnt_nxt = cnt_r + SCAN_W'(1);
        end
      end

      S_EV_RD: begin
        ax_nxt    = '0;
        state_nxt = S_EV_AX;
      end

      S_EV_AX: begin
        dctl.en    = 1'b1;
        dctl.first = (ax_r == 2'd0);
        if (ax_r == 2'd2) begin
          state_nxt = S_EV_CMP;
        end
        ax_nxt = ax_r + 2'd1;
      end

      // strict less keeps the lowest index on ties
      S_EV_CMP: begin
        if (!have_r || dist_sum < best_r) begin
          have_nxt = 1'b1;
          best_nxt = dist_sum;
          sel_nxt  = addr_r;
        end
        state_nxt = S_EV_NEXT;
      end

      S_EV_FREE: begin
        live_nxt[sel_r] = 1'b0;
        live_total_nxt  = live_total_r - CNT_W'(1);
        res_nxt.status  = ST_OK;
        res_nxt.found   = 1'b1;
        state_nxt       = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          out_cnt_nxt   = 7'(live_total_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      live_r       <= '0;
      del_r        <= '0;
      seen_r       <= '0;
      live_total_r <= '0;
      thr_r        <= THR_RESET;
      out_valid_r  <= 1'b0;
      have_r       <= 1'b0;
      cnt_r        <= '0;
      ax_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      del_r        <= del_nxt;
      seen_r       <= seen_nxt;
      live_total_r <= live_total_nxt;
      out_valid_r  <= out_valid_nxt;
      have_r       <= have_nxt;
      cnt_r        <= cnt_nxt;
      ax_r         <= ax_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    best_r     <= best_nxt;
    sel_r      <= sel_nxt;
    res_r      <= res_nxt;
    gen_in_r   <= gen_in_nxt;
    model_in_r <= model_in_nxt;
    del_in_r   <= del_in_nxt;
    cam_x_r    <= cam_x_nxt;
    cam_y_r    <= cam_y_nxt;
    cam_z_r    <= cam_z_nxt;
    out_r      <= out_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[addr_r] <= gen_wdata;
    end
    if (model_we) begin
      model_mem[addr_r] <= model_in_r;
    end
    if (pos_we) begin
      pos_mem[addr_r] <= pos_wdata;
    end
    gen_rd_r   <= gen_mem[addr_r];
    model_rd_r <= model_mem[addr_r];
    pos_rd_r   <= pos_mem[addr_r];
    seen_rd_r  <= seen_r[addr_r];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_handle_out    = out_r.handle;
  assign out_found         = out_r.found;
  assign out_model_out     = out_r.model;
  assign out_deletable_out = out_r.deletable;
  assign out_pos_x_out     = out_r.pos_x;
  assign out_pos_y_out     = out_r.pos_y;
  assign out_pos_z_out     = out_r.pos_z;
  assign out_live_count    = out_cnt_r;

endmodule

@@ rtl/gsp_dist.sv @@
// ----------------------------------------------------------------------------
// gsp_dist - shared squared-distance unit
// One axis per cycle: absolute difference, square, then accumulate.
// dist_sum is valid the cycle after the third axis was taken.
// ----------------------------------------------------------------------------
module gsp_dist (
  input  logic                      clk,
  input  gsp_pkg::gsp_dist_ctl_t    ctl,
  input  gsp_pkg::coord_t           a,
  input  gsp_pkg::coord_t           b,
  output logic [gsp_pkg::DIST_W-1:0] dist_sum
);
  import gsp_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic signed [COORD_BITS:0] diff_abs;
  logic [COORD_BITS-1:0]      mag;
  logic [2*COORD_BITS-1:0]    sq_r;
  logic [DIST_W-1:0]          acc_r;

  assign diff     = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
  assign diff_abs = diff[COORD_BITS] ? -diff : diff;
  assign mag      = diff_abs[COORD_BITS-1:0];

  // square is registered before it joins the sum
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sq_r  <= mag * mag;
      acc_r <= ctl.first ? '0 : acc_r + DIST_W'(sq_r);
    end
  end

  assign dist_sum = acc_r + DIST_W'(sq_r);

endmodule
